// ===== rtl/core/ngll_pkg.sv =====
// Shared types, constants and helpers of the GLL position parser.
// Used by every module of the block but ngll_checker; depends on nothing.
package ngll_pkg;

	// Sentence layout: header and digit positions
	localparam logic [7:0] POS_HDR_FIRST = 8'd1;
	localparam logic [7:0] POS_HDR_LAST  = 8'd5;
	localparam logic [7:0] POS_LAT_A     = 8'd7;
	localparam logic [7:0] POS_LAT_A_END = 8'd10;
	localparam logic [7:0] POS_LAT_B     = 8'd12;
	localparam logic [7:0] POS_LAT_B_END = 8'd15;
	localparam logic [7:0] POS_LON_FLAG  = 8'd21;
	localparam logic [7:0] POS_LON_A     = 8'd22;
	localparam logic [7:0] POS_LON_A_END = 8'd25;
	localparam logic [7:0] POS_LON_B     = 8'd27;
	localparam logic [7:0] POS_LON_B_END = 8'd30;
	// Second half of each coordinate skips one separator position
	localparam logic [7:0] POS_LAT_B_BASE = 8'd8;
	localparam logic [7:0] POS_LON_B_BASE = 8'd23;

	// Expected header, element 0 is the first character: G P G L L
	localparam logic [4:0][7:0] GLL_NAME = {8'h4C, 8'h4C, 8'h47, 8'h50, 8'h47};
	localparam logic [7:0] CHAR_ONE = 8'h31;

	// Conversion constants: metres per degree, hundredths of seconds per degree
	localparam logic [16:0] LAT_PER_DEG = 17'd111132;
	localparam logic [16:0] LON_PER_DEG = 17'd78847;
	localparam logic [8:0]  LON_EXTRA_DEG = 9'd100;
	// 360000 = 64 * 5625; divide by 5625 through a 2^32 reciprocal
	localparam int          PRE_SHIFT = 6;
	localparam logic [12:0] DIVISOR   = 13'd5625;
	localparam logic [19:0] RECIP     = 20'd763549;

	typedef logic [7:0][3:0] ngll_nibbles_t;

	// Fields that the capture stage hands to the conversion pipeline
	typedef struct packed {
		ngll_nibbles_t lat;
		ngll_nibbles_t lon;
		logic          lon_hundred;
		logic          header_ok;
	} ngll_fields_t;

	// One beat moving through the pipeline
	typedef struct packed {
		logic valid;
		logic cmd;
		logic match;
	} ngll_tok_t;

	function automatic logic [7:0] pair_value(input logic [3:0] hi, input logic [3:0] lo);
		pair_value = 8'(hi) * 8'd10 + 8'(lo);
	endfunction

	// minutes*6000 + seconds*100 + hundredths, at most 1006665
	function automatic logic [19:0] rem_value(input ngll_nibbles_t n);
		rem_value = 20'(pair_value(n[2], n[3])) * 20'd6000
			+ 20'(pair_value(n[4], n[5])) * 20'd100
			+ 20'(pair_value(n[6], n[7]));
	endfunction

endpackage

// ===== rtl/core/ngll_capture.sv =====
// Byte capture of the GLL parser: position counter, header and digit nibbles.
// Depends on ngll_pkg.
module ngll_capture (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  advance,
	input  logic                  command,
	input  logic [7:0]            data_byte,
	input  logic                  first_byte,
	input  logic                  last_byte,
	output ngll_pkg::ngll_tok_t   tok_s1,
	output ngll_pkg::ngll_fields_t fields
);

	logic [7:0]              byte_position_q;
	logic [4:0][7:0]         header_q;
	ngll_pkg::ngll_nibbles_t lat_q;
	ngll_pkg::ngll_nibbles_t lon_q;
	logic                    lon_hundred_q;
	logic [7:0]              pos;
	logic [3:0]              nib;

	assign pos = first_byte ? 8'd0 : byte_position_q;
	assign nib = data_byte[3:0];

	// Store a sentence byte at its position and advance the count; a last byte clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
			header_q        <= '0;
			lat_q           <= '0;
			lon_q           <= '0;
			lon_hundred_q   <= 1'b0;
		end else if (accept && !command) begin
			byte_position_q <= last_byte ? 8'd0 : pos + 8'd1;
			case (pos) inside
				[ngll_pkg::POS_HDR_FIRST:ngll_pkg::POS_HDR_LAST]:
					header_q[3'(pos - ngll_pkg::POS_HDR_FIRST)] <= data_byte;
				[ngll_pkg::POS_LAT_A:ngll_pkg::POS_LAT_A_END]:
					lat_q[3'(pos - ngll_pkg::POS_LAT_A)] <= nib;
				[ngll_pkg::POS_LAT_B:ngll_pkg::POS_LAT_B_END]:
					lat_q[3'(pos - ngll_pkg::POS_LAT_B_BASE)] <= nib;
				ngll_pkg::POS_LON_FLAG:
					lon_hundred_q <= (data_byte == ngll_pkg::CHAR_ONE);
				[ngll_pkg::POS_LON_A:ngll_pkg::POS_LON_A_END]:
					lon_q[3'(pos - ngll_pkg::POS_LON_A)] <= nib;
				[ngll_pkg::POS_LON_B:ngll_pkg::POS_LON_B_END]:
					lon_q[3'(pos - ngll_pkg::POS_LON_B_BASE)] <= nib;
				default: ;
			endcase
		end
	end

	// Launch a beat for save commands and last bytes; other bytes leave a bubble
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else if (advance) begin
			tok_s1.valid <= accept && (command || last_byte);
			tok_s1.cmd   <= command;
			tok_s1.match <= 1'b0;
		end
	end

	assign fields.lat         = lat_q;
	assign fields.lon         = lon_q;
	assign fields.lon_hundred = lon_hundred_q;
	assign fields.header_ok   = (header_q == ngll_pkg::GLL_NAME);

endmodule

// ===== rtl/core/ngll_metres.sv =====
// Conversion pipeline of the GLL parser: nibbles to whole metres for both axes.
// Depends on ngll_pkg; fed by ngll_capture.
module ngll_metres (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  ngll_pkg::ngll_tok_t    tok_s1,
	input  ngll_pkg::ngll_fields_t fields,
	output ngll_pkg::ngll_tok_t    tok_s6,
	output logic [24:0]            north_s6,
	output logic [24:0]            east_s6
);

	ngll_pkg::ngll_tok_t tok_s2, tok_s3, tok_s4, tok_s5;

	logic [8:0]  lat_deg_s2, lon_deg_s2;
	logic [19:0] lat_rem_s2, lon_rem_s2;
	logic [24:0] lat_dk_s3, lon_dk_s3, lat_dk_s4, lon_dk_s4, lat_dk_s5, lon_dk_s5;
	logic [30:0] lat_x_s3, lon_x_s3, lat_x_s4, lon_x_s4, lat_x_s5, lon_x_s5;
	logic [18:0] lat_q0_s4, lon_q0_s4, lat_q0_s5, lon_q0_s5;
	logic [30:0] lat_qd_s5, lon_qd_s5;

	logic [36:0] lat_prod, lon_prod;
	logic [50:0] lat_qm, lon_qm;
	logic [30:0] lat_r, lon_r;

	// Advance the beat through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s2 <= '0;
			tok_s3 <= '0;
			tok_s4 <= '0;
			tok_s5 <= '0;
			tok_s6 <= '0;
		end else if (advance) begin
			tok_s2.valid <= tok_s1.valid;
			tok_s2.cmd   <= tok_s1.cmd;
			tok_s2.match <= fields.header_ok;
			tok_s3       <= tok_s2;
			tok_s4       <= tok_s3;
			tok_s5       <= tok_s4;
			tok_s6       <= tok_s5;
		end
	end

	// Stage 2: split each coordinate into degrees and the sub-degree remainder
	always_ff @(posedge clk) begin
		if (advance) begin
			lat_deg_s2 <= 9'(ngll_pkg::pair_value(fields.lat[0], fields.lat[1]));
			lon_deg_s2 <= 9'(ngll_pkg::pair_value(fields.lon[0], fields.lon[1]))
				+ (fields.lon_hundred ? ngll_pkg::LON_EXTRA_DEG : 9'd0);
			lat_rem_s2 <= ngll_pkg::rem_value(fields.lat);
			lon_rem_s2 <= ngll_pkg::rem_value(fields.lon);
		end
	end

	// Stage 3: scale by metres per degree; drop the power-of-two part of 360000
	assign lat_prod = 37'(lat_rem_s2) * 37'(ngll_pkg::LAT_PER_DEG);
	assign lon_prod = 37'(lon_rem_s2) * 37'(ngll_pkg::LON_PER_DEG);

	always_ff @(posedge clk) begin
		if (advance) begin
			lat_dk_s3 <= 25'(lat_deg_s2) * 25'(ngll_pkg::LAT_PER_DEG);
			lon_dk_s3 <= 25'(lon_deg_s2) * 25'(ngll_pkg::LON_PER_DEG);
			lat_x_s3  <= lat_prod[36:ngll_pkg::PRE_SHIFT];
			lon_x_s3  <= lon_prod[36:ngll_pkg::PRE_SHIFT];
		end
	end

	// Stage 4: estimate the quotient by 5625; low by at most one
	assign lat_qm = 51'(lat_x_s3) * 51'(ngll_pkg::RECIP);
	assign lon_qm = 51'(lon_x_s3) * 51'(ngll_pkg::RECIP);

	always_ff @(posedge clk) begin
		if (advance) begin
			lat_dk_s4 <= lat_dk_s3;
			lon_dk_s4 <= lon_dk_s3;
			lat_x_s4  <= lat_x_s3;
			lon_x_s4  <= lon_x_s3;
			lat_q0_s4 <= lat_qm[50:32];
			lon_q0_s4 <= lon_qm[50:32];
		end
	end

	// Stage 5: multiply the estimate back for the remainder check
	always_ff @(posedge clk) begin
		if (advance) begin
			lat_dk_s5 <= lat_dk_s4;
			lon_dk_s5 <= lon_dk_s4;
			lat_x_s5  <= lat_x_s4;
			lon_x_s5  <= lon_x_s4;
			lat_q0_s5 <= lat_q0_s4;
			lon_q0_s5 <= lon_q0_s4;
			lat_qd_s5 <= 31'(lat_q0_s4) * 31'(ngll_pkg::DIVISOR);
			lon_qd_s5 <= 31'(lon_q0_s4) * 31'(ngll_pkg::DIVISOR);
		end
	end

	// Stage 6: correct the quotient and add the whole-degree metres
	assign lat_r = lat_x_s5 - lat_qd_s5;
	assign lon_r = lon_x_s5 - lon_qd_s5;

	always_ff @(posedge clk) begin
		if (advance) begin
			north_s6 <= lat_dk_s5 + 25'(lat_q0_s5)
				+ 25'(lat_r >= 31'(ngll_pkg::DIVISOR));
			east_s6  <= lon_dk_s5 + 25'(lon_q0_s5)
				+ 25'(lon_r >= 31'(ngll_pkg::DIVISOR));
		end
	end

endmodule

// ===== rtl/core/ngll_fix.sv =====
// Fix and origin registers of the GLL parser, and the result register.
// Depends on ngll_pkg; fed by ngll_metres.
module ngll_fix (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  ngll_pkg::ngll_tok_t tok_s6,
	input  logic [24:0]         north_s6,
	input  logic [24:0]         east_s6,
	output logic                out_valid,
	output logic                header_matched,
	output logic signed [25:0]  x_offset,
	output logic signed [25:0]  y_offset
);

	logic [24:0] fix_north_q, fix_east_q, origin_north_q, origin_east_q;
	logic [24:0] north_next, east_next;
	logic        is_result, take_fix;

	assign is_result  = tok_s6.valid && !tok_s6.cmd;
	assign take_fix   = is_result && tok_s6.match;
	assign north_next = take_fix ? north_s6 : fix_north_q;
	assign east_next  = take_fix ? east_s6 : fix_east_q;

	// Update the fix on a matched sentence; copy it to the origin on a save
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_north_q    <= '0;
			fix_east_q     <= '0;
			origin_north_q <= '0;
			origin_east_q  <= '0;
			out_valid      <= 1'b0;
		end else if (advance) begin
			fix_north_q <= north_next;
			fix_east_q  <= east_next;
			if (tok_s6.valid && tok_s6.cmd) begin
				origin_north_q <= fix_north_q;
				origin_east_q  <= fix_east_q;
			end
			out_valid <= is_result;
		end
	end

	// Load the result beat
	always_ff @(posedge clk) begin
		if (advance && is_result) begin
			header_matched <= tok_s6.match;
			x_offset       <= signed'({1'b0, east_next} - {1'b0, origin_east_q});
			y_offset       <= signed'({1'b0, north_next} - {1'b0, origin_north_q});
		end
	end

endmodule

// ===== rtl/core/nmea_gll_position_parser.sv =====
// NMEA GLL position parser: one sentence byte or save command per beat. A beat
// is accepted every cycle while the result register is empty or being taken;
// in_stall rises only while a result is held by out_stall. The result of a last
// byte passes through five conversion stages (reciprocal divide by 360000 with
// one correction step) and then the result register. A held result freezes
// every stage. Save commands and other bytes give no result beat.
// Depends on ngll_pkg, ngll_capture, ngll_metres and ngll_fix.
module nmea_gll_position_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               command,
	input  logic [7:0]         data_byte,
	input  logic               first_byte,
	input  logic               last_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               header_matched,
	output logic signed [25:0] x_offset,
	output logic signed [25:0] y_offset
);

	ngll_pkg::ngll_tok_t    tok_s1, tok_s6;
	ngll_pkg::ngll_fields_t fields;
	logic [24:0]            north_s6, east_s6;
	logic                   advance, accept;

	// Move the whole pipeline unless a held result is stalled
	assign advance  = !out_valid || !out_stall;
	assign in_stall = !advance;
	assign accept   = in_valid && advance;

	ngll_capture u_capture (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.advance    (advance),
		.command    (command),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.tok_s1     (tok_s1),
		.fields     (fields)
	);

	ngll_metres u_metres (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.tok_s1   (tok_s1),
		.fields   (fields),
		.tok_s6   (tok_s6),
		.north_s6 (north_s6),
		.east_s6  (east_s6)
	);

	ngll_fix u_fix (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.tok_s6         (tok_s6),
		.north_s6       (north_s6),
		.east_s6        (east_s6),
		.out_valid      (out_valid),
		.header_matched (header_matched),
		.x_offset       (x_offset),
		.y_offset       (y_offset)
	);

endmodule

// ===== rtl/core/ngll_checker.sv =====
// Port-level checks of the GLL position parser, bound to the top level.
// Depends on nmea_gll_position_parser ports only.
module ngll_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               command,
	input logic [7:0]         data_byte,
	input logic               first_byte,
	input logic               last_byte,
	input logic               out_valid,
	input logic               out_stall,
	input logic               header_matched,
	input logic signed [25:0] x_offset,
	input logic signed [25:0] y_offset
);

	// Hold a stalled result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(header_matched)
			&& $stable(x_offset) && $stable(y_offset))
		else $error("stalled result beat changed");

	// Stall input only behind a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// Offsets of two 25-bit values never reach the negative limit
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> x_offset != -26'sd33554432)
		else $error("x offset out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> y_offset != -26'sd33554432)
		else $error("y offset out of range");

endmodule

bind nmea_gll_position_parser ngll_checker u_checker (.*);
